>>> hw/rtl/rse_pkg.sv
// Shared types and constants for the RV32I subset executor.
package rse_pkg;

  // Field widths of the instruction and result beats.
  localparam int XLEN      = 32;
  localparam int FUNC_W    = 5;
  localparam int REG_IDX_W = 5;
  localparam int REG_COUNT = 32;
  localparam int LUI_SHIFT = 12;

  // Operation codes carried in the func field.
  typedef enum logic [FUNC_W-1:0] {
    FN_ADD  = 5'd0,
    FN_SUB  = 5'd1,
    FN_AND  = 5'd2,
    FN_OR   = 5'd3,
    FN_XOR  = 5'd4,
    FN_SLT  = 5'd5,
    FN_SLL  = 5'd6,
    FN_SRA  = 5'd7,
    FN_ADDI = 5'd8,
    FN_ANDI = 5'd9,
    FN_ORI  = 5'd10,
    FN_XORI = 5'd11,
    FN_SLTI = 5'd12,
    FN_LUI  = 5'd13,
    FN_LW   = 5'd14,
    FN_LB   = 5'd15,
    FN_SW   = 5'd16,
    FN_SB   = 5'd17
  } func_t;

endpackage

>>> hw/rtl/rse_if.sv
// Valid/ready channel interfaces for instruction and result beats.
interface rse_in_if;
  import rse_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [REG_IDX_W-1:0]    rd;
  logic [REG_IDX_W-1:0]    rs1;
  logic [REG_IDX_W-1:0]    rs2;
  logic signed [XLEN-1:0]  imm;

  modport source (output valid, func, rd, rs1, rs2, imm, input ready);
  modport sink   (input valid, func, rd, rs1, rs2, imm, output ready);
endinterface

interface rse_out_if;
  import rse_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    reg_write;
  logic [REG_IDX_W-1:0]    reg_index;
  logic signed [XLEN-1:0]  reg_value;

  modport source (output valid, reg_write, reg_index, reg_value, input ready);
  modport sink   (input valid, reg_write, reg_index, reg_value, output ready);
endinterface

>>> hw/rtl/riscv_subset_executor_unit.sv
// RV32I subset executor: register file, byte memory and a three-stage pipeline.
//
// Each instruction beat produces exactly one result beat, after the execute and
// memory stages and the output register. While the result side is ready, the
// pipeline sustains one instruction per cycle, loads included: the register file
// is a two-read-port synchronous memory read in the accept cycle, the byte memory
// is four byte-wide banks read in the execute cycle, and results (load data too)
// are forwarded to the following instruction so no stall is ever inserted
// between instructions. Unaligned word accesses and accesses that wrap past the
// end of memory are handled without a stall. MEM_BYTES must be a power of two.
// After reset the byte memory is cleared one row of four bytes per cycle;
// instr.ready stays low during that pass.
module riscv_subset_executor_unit #(
  parameter int MEM_BYTES = 65536
) (
  input logic       clk,
  input logic       rst,
  rse_in_if.sink    instr,
  rse_out_if.source result
);
  import rse_pkg::*;

  localparam int ADDR_W = $clog2(MEM_BYTES);
  localparam int ROW_W  = ADDR_W - 2;
  localparam int ROWS   = MEM_BYTES / 4;

  // Pipeline control.
  logic in_fire, s1_fire, s2_fire;
  logic s1_valid, s2_valid, out_valid;

  // Clearing pass over the byte memory.
  logic             clearing;
  logic [ROW_W-1:0] clr_row;

  // Register file, its valid bits and read data.
  logic [XLEN-1:0]      rf [REG_COUNT];
  logic [REG_COUNT-1:0] rf_ok;
  logic [XLEN-1:0]      rf_a_q, rf_b_q;
  logic [REG_IDX_W-1:0] in_rsb;
  logic                 in_is_store;

  // Execute stage registers.
  logic [FUNC_W-1:0]    s1_func;
  logic [REG_IDX_W-1:0] s1_rd, s1_rs1, s1_rsb;
  logic [XLEN-1:0]      s1_imm;
  logic                 fwd_a_hit, fwd_b_hit;
  logic [XLEN-1:0]      fwd_val;

  // Execute stage logic.
  logic [XLEN-1:0]   op_a, op_b, alu_val, ea_sum;
  logic [4:0]        sh;
  logic              s1_wr, s1_lw, s1_lb, s1_sw, s1_sb;
  logic [ADDR_W-1:0] ea;
  logic [ROW_W-1:0]  base_row;
  logic [1:0]        ea_off;

  // Memory stage registers.
  logic                 s2_wr, s2_lw, s2_lb;
  logic [REG_IDX_W-1:0] s2_rd;
  logic [XLEN-1:0]      s2_alu;
  logic [1:0]           s2_off;
  logic [7:0]           bq [4];
  logic [XLEN-1:0]      s2_val;

  // Writeback to the register file.
  logic                 wb_we;
  logic [REG_IDX_W-1:0] wb_idx;
  logic [XLEN-1:0]      wb_val;

  // Output register.
  logic                 res_write;
  logic [REG_IDX_W-1:0] res_index;
  logic [XLEN-1:0]      res_value;

  // Stage handshakes: each stage moves when the one after it is empty or moving.
  assign s2_fire     = s2_valid && (!out_valid || result.ready);
  assign s1_fire     = s1_valid && (!s2_valid || s2_fire);
  assign instr.ready = !clearing && (!s1_valid || s1_fire);
  assign in_fire     = instr.valid && instr.ready;

  // Stores read their data register on the second port.
  assign in_is_store = (instr.func == FN_SW) || (instr.func == FN_SB);
  assign in_rsb      = in_is_store ? instr.rd : instr.rs2;

  assign wb_we  = s2_fire && s2_wr;
  assign wb_idx = s2_rd;
  assign wb_val = s2_val;

  // Clearing pass sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_row  <= '0;
    end else if (clearing) begin
      clr_row <= clr_row + ROW_W'(1);
      if (clr_row == ROW_W'(ROWS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Register file: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wb_we) begin
      rf[wb_idx] <= wb_val;
    end
    if (in_fire) begin
      rf_a_q <= rf[instr.rs1];
      rf_b_q <= rf[in_rsb];
    end
  end

  // Entries never written read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_ok <= '0;
    end else if (wb_we) begin
      rf_ok[wb_idx] <= 1'b1;
    end
  end

  // Execute stage capture, including a write that lands in the read cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func   <= instr.func;
      s1_rd     <= instr.rd;
      s1_rs1    <= instr.rs1;
      s1_rsb    <= in_rsb;
      s1_imm    <= instr.imm;
      fwd_a_hit <= wb_we && (wb_idx == instr.rs1);
      fwd_b_hit <= wb_we && (wb_idx == in_rsb);
      fwd_val   <= wb_val;
    end
  end

  // Operand selection: the memory stage holds the newest older result.
  always_comb begin
    if (s1_rs1 == '0) begin
      op_a = '0;
    end else if (s2_valid && s2_wr && (s2_rd == s1_rs1)) begin
      op_a = s2_val;
    end else if (fwd_a_hit) begin
      op_a = fwd_val;
    end else if (rf_ok[s1_rs1]) begin
      op_a = rf_a_q;
    end else begin
      op_a = '0;
    end

    if (s1_rsb == '0) begin
      op_b = '0;
    end else if (s2_valid && s2_wr && (s2_rd == s1_rsb)) begin
      op_b = s2_val;
    end else if (fwd_b_hit) begin
      op_b = fwd_val;
    end else if (rf_ok[s1_rsb]) begin
      op_b = rf_b_q;
    end else begin
      op_b = '0;
    end
  end

  // ALU and instruction class.
  always_comb begin
    sh      = s1_imm[4:0];
    alu_val = '0;
    s1_wr   = 1'b1;
    s1_lw   = 1'b0;
    s1_lb   = 1'b0;
    s1_sw   = 1'b0;
    s1_sb   = 1'b0;
    case (s1_func)
      FN_ADD:  alu_val = op_a + op_b;
      FN_SUB:  alu_val = op_a - op_b;
      FN_AND:  alu_val = op_a & op_b;
      FN_OR:   alu_val = op_a | op_b;
      FN_XOR:  alu_val = op_a ^ op_b;
      FN_SLT:  alu_val = XLEN'($signed(op_a) < $signed(op_b));
      FN_SLL:  alu_val = op_a << sh;
      FN_SRA:  alu_val = XLEN'($signed(op_a) >>> sh);
      FN_ADDI: alu_val = op_a + s1_imm;
      FN_ANDI: alu_val = op_a & s1_imm;
      FN_ORI:  alu_val = op_a | s1_imm;
      FN_XORI: alu_val = op_a ^ s1_imm;
      FN_SLTI: alu_val = XLEN'($signed(op_a) < $signed(s1_imm));
      FN_LUI:  alu_val = s1_imm << LUI_SHIFT;
      FN_LW:   s1_lw = 1'b1;
      FN_LB:   s1_lb = 1'b1;
      FN_SW: begin
        s1_sw = 1'b1;
        s1_wr = 1'b0;
      end
      FN_SB: begin
        s1_sb = 1'b1;
        s1_wr = 1'b0;
      end
      default: s1_wr = 1'b0;
    endcase
    if (s1_rd == '0) begin
      s1_wr = 1'b0;
    end
  end

  // Effective address, split into a bank row and a byte offset.
  assign ea_sum   = op_a + s1_imm;
  assign ea       = ea_sum[ADDR_W-1:0];
  assign base_row = ea[ADDR_W-1:2];
  assign ea_off   = ea[1:0];

  // Byte memory: bank j holds the bytes whose address is j modulo four.
  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [7:0]       bmem [ROWS];
    logic [ROW_W-1:0] row;
    logic [1:0]       lane;
    logic             st_en;

    // Bytes below the offset belong to the next row.
    assign row   = base_row + ROW_W'(ea_off > 2'(j));
    assign lane  = 2'(2'(j) - ea_off);
    assign st_en = s1_fire && (s1_sw || (s1_sb && (lane == 2'd0)));

    always_ff @(posedge clk) begin
      if (clearing) begin
        bmem[clr_row] <= 8'h00;
      end else if (st_en) begin
        bmem[row] <= op_b[8*lane +: 8];
      end
      if (s1_fire && (s1_lw || s1_lb)) begin
        bq[j] <= bmem[row];
      end
    end
  end

  // Memory stage capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_fire) begin
      s2_valid <= 1'b1;
    end else if (s2_fire) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_wr  <= s1_wr;
      s2_lw  <= s1_lw;
      s2_lb  <= s1_lb;
      s2_rd  <= s1_rd;
      s2_alu <= alu_val;
      s2_off <= ea_off;
    end
  end

  // Load data assembly from the rotated bank outputs.
  always_comb begin
    if (s2_lw) begin
      s2_val = {bq[2'(s2_off + 2'd3)], bq[2'(s2_off + 2'd2)],
                bq[2'(s2_off + 2'd1)], bq[s2_off]};
    end else if (s2_lb) begin
      s2_val = {{(XLEN-8){bq[s2_off][7]}}, bq[s2_off]};
    end else begin
      s2_val = s2_alu;
    end
  end

  // Output register; a result with no write reports zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      res_write <= s2_wr;
      res_index <= s2_wr ? s2_rd : '0;
      res_value <= s2_wr ? s2_val : '0;
    end
  end

  assign result.valid     = out_valid;
  assign result.reg_write = res_write;
  assign result.reg_index = res_index;
  assign result.reg_value = res_value;

endmodule

>>> hw/rtl/rse_checker.sv
// Port-level checks for the executor, bound to its top level.
module rse_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic                          res_write,
  input logic [rse_pkg::REG_IDX_W-1:0] res_index,
  input logic [rse_pkg::XLEN-1:0]      res_value
);
  import rse_pkg::*;

  // A stalled result beat keeps its contents.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_write) &&
    $stable(res_index) && $stable(res_value))
    else $error("result beat changed while stalled");

  // A beat without a register write carries zero index and value.
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_write |-> (res_index == '0) && (res_value == '0))
    else $error("result without write has nonzero fields");

  // Register zero is never reported as written.
  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_write |-> res_index != '0)
    else $error("write to register zero reported");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // The memory clearing pass blocks instructions right after reset.
  a_reset_busy: assert property (@(posedge clk)
    $past(rst) |-> !in_ready)
    else $error("instruction accepted during memory clearing");

endmodule

bind riscv_subset_executor_unit rse_checker u_rse_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (instr.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_write (result.reg_write),
  .res_index (result.reg_index),
  .res_value (result.reg_value)
);
